[hw/rtl/swdd_pkg.sv]
// ============================================================================
// swdd_pkg
// Shared types, constants and code tables for the switch debounce and
// seven-segment display controller.
// ============================================================================
`default_nettype none

package swdd_pkg;

   // Field widths of the stream words.
   localparam int SEG_W      = 7;
   localparam int CATH_W     = 4;
   localparam int PIN_W      = 4;
   localparam int SW_W       = 4;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Configuration port widths.
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 10;

   // Default build parameters.
   localparam int DIGIT_COUNT_DEF  = 4;
   localparam int SWITCH_COUNT_DEF = 4;

   // Register reset values.
   localparam logic [2:0] MODE_RST     = 3'd0;
   localparam logic [3:0] DEBOUNCE_RST = 4'd6;
   localparam logic [7:0] POLL_RST     = 8'd2;
   localparam logic [7:0] MUX_RST      = 8'd2;
   localparam logic [9:0] SLOW_RST     = 10'd500;
   localparam logic [9:0] FAST_RST     = 10'd100;

   // Segment pattern of the digit zero, shown after reset.
   localparam logic [SEG_W-1:0] SEG_ZERO = 7'h3F;

   // Configuration register indexes.
   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_DEBOUNCE = 3'd1,
      CSR_POLL     = 3'd2,
      CSR_MUX      = 3'd3,
      CSR_SLOW     = 3'd4,
      CSR_FAST     = 3'd5
   } csr_index_type;

   // Operating modes.
   typedef enum logic [2:0] {
      MODE_FOLLOW = 3'd0,
      MODE_TOGGLE = 3'd1,
      MODE_BLINK  = 3'd2,
      MODE_COUNT  = 3'd3,
      MODE_BINARY = 3'd4
   } mode_type;

   // LED setting picked by switches 0 and 1 in blink mode.
   typedef enum logic [1:0] {
      BLINK_OFF  = 2'd0,
      BLINK_SLOW = 2'd1,
      BLINK_FAST = 2'd2,
      BLINK_ON   = 2'd3
   } blink_sel_type;

   // Outcome of one tick of the debouncer.
   typedef struct packed {
      logic            poll;
      logic            changed;
      logic [SW_W-1:0] stable;
      logic [SW_W-1:0] previous;
   } sw_event_type;

   // Digit code updates requested by the mode logic.
   typedef struct packed {
      logic            two_wr;
      logic [SW_W-1:0] two_val;
      logic            bin_wr;
      logic [SW_W-1:0] bin_val;
   } digit_upd_type;

   // Seven-segment code of a decimal digit, blank for other values.
   function automatic logic [SEG_W-1:0] digit_segments(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      unique case (digit)
         4'd0:    code = 7'h3F;
         4'd1:    code = 7'h06;
         4'd2:    code = 7'h5B;
         4'd3:    code = 7'h4F;
         4'd4:    code = 7'h66;
         4'd5:    code = 7'h6D;
         4'd6:    code = 7'h7D;
         4'd7:    code = 7'h07;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h6F;
         default: code = '0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/switch_debounce_display_controller_core.sv]
// ============================================================================
// switch_debounce_display_controller_core
// Switch debouncer with a multiplexed seven-segment display and one LED.
// ============================================================================
// Usage:
//   Each word on the req_ stream is one millisecond tick carrying the raw,
//   active-low levels of the switches. For every tick the block returns one
//   word on the rsp_ stream: the latched segment and cathode lines, the LED
//   level and the debounced switch value after that tick.
//   The csr_ channel writes the six configuration registers and is always
//   ready. Write it only while no tick is in flight; this is not enforced.
// Flow and throughput:
//   A tick waits in the input register and is then processed into the
//   state registers, where rsp_tvalid rises. One tick per cycle is
//   sustained while rsp_tready stays high.
// Stalls and reset:
//   The state registers double as the result register, so while rsp_tready
//   is low the result holds and one further tick waits in the input
//   register; req_tready then drops. Reset clears all state, loads the
//   register defaults and leaves both streams empty.
// ============================================================================
`default_nettype none

module switch_debounce_display_controller_core
   import swdd_pkg::*;
#(
   parameter int DIGIT_COUNT  = DIGIT_COUNT_DEF,
   parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] switch_pins
   // Result stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [6:0] segments, [10:7] cathodes, [11] led_on, [15:12] stable_switches
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration write channel.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CFG_IDX_W-1:0]  csr_addr,
   input  wire logic [CFG_DATA_W-1:0] csr_wdata
);

   logic [2:0]       mode_ff;
   logic [3:0]       debounce_ff;
   logic [7:0]       poll_ff;
   logic [7:0]       mux_ff;
   logic [9:0]       slow_ff;
   logic [9:0]       fast_ff;

   logic             in_valid_ff, in_valid_in;
   logic [PIN_W-1:0] pins_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;
   logic             req_take;
   mode_type         mode_sel;

   sw_event_type     ev;
   digit_upd_type    upd;
   logic [SW_W-1:0]  stable_sw;
   logic             led;
   logic [SEG_W-1:0] seg;
   logic [CATH_W-1:0] cath;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RST;
         debounce_ff <= DEBOUNCE_RST;
         poll_ff     <= POLL_RST;
         mux_ff      <= MUX_RST;
         slow_ff     <= SLOW_RST;
         fast_ff     <= FAST_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MODE:     mode_ff     <= csr_wdata[2:0];
            CSR_DEBOUNCE: debounce_ff <= csr_wdata[3:0];
            CSR_POLL:     poll_ff     <= csr_wdata[7:0];
            CSR_MUX:      mux_ff      <= csr_wdata[7:0];
            CSR_SLOW:     slow_ff     <= csr_wdata;
            CSR_FAST:     fast_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Unused mode codes behave as follow mode.
   assign mode_sel = (mode_ff > 3'(MODE_BINARY)) ? MODE_FOLLOW : mode_type'(mode_ff);

   // Handshake: a tick advances when the result slot is free or being taken.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         pins_ff <= req_tdata[PIN_W-1:0];
      end
   end

   swdd_debounce #(
      .SWITCH_COUNT (SWITCH_COUNT)
   ) u_debounce (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .pins             (pins_ff),
      .debounce_samples (debounce_ff),
      .poll_period      (poll_ff),
      .ev               (ev),
      .stable_out       (stable_sw)
   );

   swdd_mode u_mode (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .mode             (mode_sel),
      .ev               (ev),
      .slow_half_period (slow_ff),
      .fast_half_period (fast_ff),
      .led_out          (led),
      .upd              (upd)
   );

   swdd_display #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_display (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .binary_mode (mode_sel == MODE_BINARY),
      .mux_period  (mux_ff),
      .upd         (upd),
      .segments    (seg),
      .cathodes    (cath)
   );

   // Result word straight from the state registers.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {stable_sw, led, cath, seg};

endmodule

`default_nettype wire

[hw/rtl/swdd_debounce.sv]
// ============================================================================
// swdd_debounce
// Poll timer and switch debouncer. Samples the active-low pins every poll
// period and accepts a value once it has repeated the set number of times.
// ============================================================================
`default_nettype none

module swdd_debounce
   import swdd_pkg::*;
#(
   parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [PIN_W-1:0] pins,
   input  wire logic [3:0]       debounce_samples,
   input  wire logic [7:0]       poll_period,
   output sw_event_type          ev,
   output logic [SW_W-1:0]       stable_out
);

   logic [SWITCH_COUNT-1:0] last_ff, last_in;
   logic [SWITCH_COUNT-1:0] stable_ff, stable_in;
   logic [SWITCH_COUNT-1:0] prev_ff, prev_in;
   logic [3:0]              match_ff, match_in;
   logic [7:0]              poll_cnt_ff, poll_cnt_in;
   logic [SWITCH_COUNT-1:0] raw;
   logic [3:0]              need;
   logic                    poll;
   logic                    changed;

   // Debounce step on a poll tick; the poll timer reloads after each poll.
   always_comb begin
      raw       = ~pins[SWITCH_COUNT-1:0];
      need      = (debounce_samples == 4'd0) ? 4'd1 : debounce_samples;
      poll      = (poll_cnt_ff == 8'd0);
      last_in   = last_ff;
      stable_in = stable_ff;
      prev_in   = prev_ff;
      match_in  = match_ff;
      changed   = 1'b0;
      if (poll) begin
         if (raw == last_ff) begin
            if (match_ff < need) begin
               match_in = match_ff + 4'd1;
               if ((match_in == need) && (stable_ff != raw)) begin
                  prev_in   = stable_ff;
                  stable_in = raw;
                  changed   = 1'b1;
               end
            end
         end else begin
            last_in  = raw;
            match_in = 4'd0;
         end
         poll_cnt_in = (poll_period == 8'd0) ? 8'd0 : poll_period - 8'd1;
      end else begin
         poll_cnt_in = poll_cnt_ff - 8'd1;
      end
   end

   assign ev.poll     = poll;
   assign ev.changed  = changed;
   assign ev.stable   = SW_W'(stable_in);
   assign ev.previous = SW_W'(prev_in);
   assign stable_out  = SW_W'(stable_ff);

   // Debouncer state, advanced once per tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= '0;
         stable_ff   <= '0;
         prev_ff     <= '0;
         match_ff    <= '0;
         poll_cnt_ff <= '0;
      end else if (step) begin
         last_ff     <= last_in;
         stable_ff   <= stable_in;
         prev_ff     <= prev_in;
         match_ff    <= match_in;
         poll_cnt_ff <= poll_cnt_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/swdd_mode.sv]
// ============================================================================
// swdd_mode
// Mode behavior: LED control, blink timer, press counter and the digit code
// updates that each mode asks of the display.
// ============================================================================
`default_nettype none

module swdd_mode
   import swdd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire mode_type      mode,
   input  wire sw_event_type  ev,
   input  wire logic [9:0]    slow_half_period,
   input  wire logic [9:0]    fast_half_period,
   output logic               led_out,
   output digit_upd_type      upd
);

   logic          led_ff, led_in;
   logic [9:0]    blink_ff, blink_in;
   logic [3:0]    press_ff, press_in;
   logic [3:0]    shown_ff, shown_in;
   logic          press;
   logic          led_mid;
   logic [9:0]    blink_mid;
   logic [9:0]    half;
   blink_sel_type sel;

   always_comb begin
      press     = ev.changed & ev.stable[0] & ~ev.previous[0];
      led_mid   = led_ff;
      blink_mid = blink_ff;
      press_in  = press_ff;
      shown_in  = shown_ff;
      upd       = '0;

      // Poll-time behavior of each mode.
      if (ev.poll) begin
         unique case (mode)
            MODE_TOGGLE: begin
               if (press) led_mid = ~led_ff;
               upd.two_wr  = ev.changed;
               upd.two_val = ev.stable;
            end
            MODE_BLINK: begin
               if (ev.changed && ((ev.stable[1:0] ^ ev.previous[1:0]) != 2'b00)) begin
                  blink_mid = '0;
               end
               upd.two_wr  = 1'b1;
               upd.two_val = ev.stable;
            end
            MODE_COUNT: begin
               if (press) begin
                  press_in    = (press_ff >= 4'd9) ? 4'd0 : press_ff + 4'd1;
                  upd.two_wr  = 1'b1;
                  upd.two_val = press_in;
               end
            end
            MODE_BINARY: begin
               upd.bin_wr  = 1'b1;
               upd.bin_val = ev.stable;
            end
            MODE_FOLLOW: begin
               if (ev.changed) shown_in = ev.stable;
               upd.two_wr  = ev.changed;
               upd.two_val = ev.stable;
               led_mid     = shown_in[0];
            end
            default: begin
            end
         endcase
      end

      // Blink timer runs every tick; it stays cleared outside blinking.
      sel      = blink_sel_type'(ev.stable[1:0]);
      half     = (sel == BLINK_SLOW) ? slow_half_period : fast_half_period;
      led_in   = led_mid;
      blink_in = '0;
      if (mode == MODE_BLINK) begin
         unique case (sel)
            BLINK_OFF: led_in = 1'b0;
            BLINK_ON:  led_in = 1'b1;
            BLINK_SLOW, BLINK_FAST: begin
               if (blink_mid == 10'd0) begin
                  led_in   = ~led_mid;
                  blink_in = (half == 10'd0) ? 10'd0 : half - 10'd1;
               end else begin
                  blink_in = blink_mid - 10'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign led_out = led_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff   <= 1'b0;
         blink_ff <= '0;
         press_ff <= '0;
         shown_ff <= '0;
      end else if (step) begin
         led_ff   <= led_in;
         blink_ff <= blink_in;
         press_ff <= press_in;
         shown_ff <= shown_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/swdd_display.sv]
// ============================================================================
// swdd_display
// Digit code store and display multiplexer. Every mux period the next
// digit's segment code and cathode pattern are latched onto the outputs.
// ============================================================================
`default_nettype none

module swdd_display
   import swdd_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              binary_mode,
   input  wire logic [7:0]        mux_period,
   input  wire digit_upd_type     upd,
   output logic [SEG_W-1:0]       segments,
   output logic [CATH_W-1:0]      cathodes
);

   localparam int IDX_W = $clog2(DIGIT_COUNT);

   logic [SEG_W-1:0]  codes_ff [DIGIT_COUNT];
   logic [SEG_W-1:0]  codes_in [DIGIT_COUNT];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        mux_cnt_ff, mux_cnt_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [CATH_W-1:0] cath_ff, cath_in;
   logic              two_high;
   logic [3:0]        two_units;

   // Digit code updates: two decimal digits or one binary digit per line.
   always_comb begin
      two_high  = (upd.two_val >= 4'd10);
      two_units = two_high ? upd.two_val - 4'd10 : upd.two_val;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         codes_in[i] = codes_ff[i];
      end
      if (upd.two_wr) begin
         codes_in[0] = digit_segments(two_units);
         codes_in[1] = digit_segments({3'b000, two_high});
      end
      if (upd.bin_wr) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            codes_in[i] = digit_segments({3'b000, upd.bin_val[i]});
         end
      end
   end

   // Multiplex step, which reads the codes held before this tick.
   always_comb begin
      seg_in  = seg_ff;
      cath_in = cath_ff;
      idx_in  = idx_ff;
      if (mux_cnt_ff == 8'd0) begin
         seg_in  = codes_ff[idx_ff];
         cath_in = ~(CATH_W'(1) << idx_ff);
         if (binary_mode) begin
            idx_in = (idx_ff == IDX_W'(DIGIT_COUNT - 1)) ? '0 : idx_ff + IDX_W'(1);
         end else begin
            idx_in = (idx_ff == '0) ? IDX_W'(1) : '0;
         end
         mux_cnt_in = (mux_period == 8'd0) ? 8'd0 : mux_period - 8'd1;
      end else begin
         mux_cnt_in = mux_cnt_ff - 8'd1;
      end
   end

   assign segments = seg_ff;
   assign cathodes = cath_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            codes_ff[i] <= (i < 2) ? SEG_ZERO : '0;
         end
         idx_ff     <= '0;
         mux_cnt_ff <= '0;
         seg_ff     <= '0;
         cath_ff    <= '1;
      end else if (step) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            codes_ff[i] <= codes_in[i];
         end
         idx_ff     <= idx_in;
         mux_cnt_ff <= mux_cnt_in;
         seg_ff     <= seg_in;
         cath_ff    <= cath_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/swdd_checker.sv]
// ============================================================================
// swdd_checker
// Port-level checks on the controller's streams, bound to the top level.
// ============================================================================
`default_nettype none

module swdd_checker
   import swdd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // At most one digit is driven while a result word is valid.
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(~rsp_tdata[10:7]))
      else $error("more than one cathode line active");

   // Reset leaves the result stream empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word present after reset");

   // With the result slot free, a pending input is never refused.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && $past(!reset) |-> req_tready)
      else $error("input refused while result slot empty");

endmodule

bind switch_debounce_display_controller_core swdd_checker u_swdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[test/switch_debounce_display_controller_core_tb.sv]
// ----------------------------------------------------------------------------
// switch_debounce_display_controller_core_tb
// Checks every result word of the debounce and display controller against a
// cycle-free model of the tick behavior. A short table of ticks is walked
// first, then phases of held switch patterns with bounce noise run under
// register settings that cover every mode, the zero and maximum periods and
// the unused mode codes, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module switch_debounce_display_controller_core_tb;
   import swdd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int          PHASES      = 16;

   // Mode codes that the block treats like follow mode.
   localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
   // Register indexes with no register behind them.
   localparam logic [CFG_IDX_W-1:0] CSR_SPARE_FIRST = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   // Segment patterns of the decimal digits.
   localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // One result word, laid out as on rsp_tdata.
   typedef struct packed {
      logic [SW_W-1:0]   stable_switches;
      logic              led_on;
      logic [CATH_W-1:0] cathodes;
      logic [SEG_W-1:0]  segments;
   } disp_word_type;

   // One row of the directed table; pinned rows carry a typed-in result.
   typedef struct packed {
      logic [PIN_W-1:0] pins;
      logic             pinned;
      disp_word_type    want;
   } tick_row_type;

   // Pins are active low: 4'hF means all switches open.
   localparam tick_row_type DIRECTED [24] = '{
      {4'hF, 1'b1, 4'h0, 1'b0, 4'b1110, SEG_ZERO},
      {4'hF, 1'b1, 4'h0, 1'b0, 4'b1110, SEG_ZERO},
      {4'hF, 1'b1, 4'h0, 1'b0, 4'b1101, SEG_ZERO},
      {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0},
      {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0},
      {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0},
      {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0},
      {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0},
      {4'h0, 1'b0, 16'h0},
      {4'hE, 1'b0, 16'h0}, {4'h7, 1'b0, 16'h0}, {4'h5, 1'b0, 16'h0},
      {4'hA, 1'b0, 16'h0}, {4'h0, 1'b0, 16'h0}
   };

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_addr    = '0;
   logic [CFG_DATA_W-1:0] csr_wdata   = '0;

   // Typed-in result that travels with the tick word being offered.
   logic          row_pinned = 1'b0;
   disp_word_type row_want   = '0;

   logic          gaps_on = 1'b1;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   disp_word_type expected_words [$];

   // Predictor copy of the registers.
   logic [2:0] cfg_mode;
   logic [3:0] cfg_debounce;
   logic [7:0] cfg_poll, cfg_mux;
   logic [9:0] cfg_slow, cfg_fast;

   // Predictor copy of the block state.
   logic [SW_W-1:0]   sw_last, sw_matches, sw_stable, sw_prev, shown_value, press_total;
   logic [7:0]        poll_left, mux_left;
   logic [9:0]        blink_left;
   logic [1:0]        digit_sel;
   logic [SEG_W-1:0]  glyphs [4];
   logic [SEG_W-1:0]  seg_q;
   logic [CATH_W-1:0] cath_q;
   logic              led_q;

   switch_debounce_display_controller_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A period or count of zero behaves as one.
   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      return (v == '0) ? 10'd1 : v;
   endfunction

   // Loads the two low digits with a value in decimal.
   task automatic show_decimal(input logic [3:0] v);
      glyphs[0] = DIGIT_GLYPH[v % 10];
      glyphs[1] = DIGIT_GLYPH[v / 10];
   endtask

   task automatic display_reset();
      cfg_mode     = MODE_RST;
      cfg_debounce = DEBOUNCE_RST;
      cfg_poll     = POLL_RST;
      cfg_mux      = MUX_RST;
      cfg_slow     = SLOW_RST;
      cfg_fast     = FAST_RST;
      sw_last      = '0;
      sw_matches   = '0;
      sw_stable    = '0;
      sw_prev      = '0;
      shown_value  = '0;
      press_total  = '0;
      poll_left    = '0;
      mux_left     = '0;
      blink_left   = '0;
      digit_sel    = '0;
      glyphs       = '{SEG_ZERO, SEG_ZERO, 7'h00, 7'h00};
      seg_q        = '0;
      cath_q       = '1;
      led_q        = 1'b0;
   endtask

   task automatic display_write(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
      case (idx)
         CSR_MODE:     cfg_mode     = data[2:0];
         CSR_DEBOUNCE: cfg_debounce = data[3:0];
         CSR_POLL:     cfg_poll     = data[7:0];
         CSR_MUX:      cfg_mux      = data[7:0];
         CSR_SLOW:     cfg_slow     = data;
         CSR_FAST:     cfg_fast     = data;
         default:      ;
      endcase
   endtask

   // Advances the display state by one tick and returns the word it reports.
   task automatic advance_display_tick(input logic [PIN_W-1:0] pins,
                                       output disp_word_type res);
      logic [2:0]      m;
      logic [SW_W-1:0] need, raw;
      logic            changed, press;
      logic [1:0]      sel;
      m = (cfg_mode <= MODE_BINARY) ? cfg_mode : MODE_FOLLOW;

      // The multiplex step latches the current digit first.
      if (mux_left == '0) begin
         seg_q  = glyphs[digit_sel];
         cath_q = ~(4'b0001 << digit_sel);
         if (m == MODE_BINARY)
            digit_sel = (digit_sel == 2'(DIGIT_COUNT_DEF - 1)) ? 2'd0 : digit_sel + 2'd1;
         else
            digit_sel = (digit_sel == 2'd0) ? 2'd1 : 2'd0;
         mux_left = 8'(at_least_one(10'(cfg_mux)) - 10'd1);
      end else begin
         mux_left = mux_left - 8'd1;
      end

      // Debounce the sample, then let the mode act on the outcome.
      if (poll_left == '0) begin
         need    = 4'(at_least_one(10'(cfg_debounce)));
         raw     = ~pins;
         changed = 1'b0;
         if (raw == sw_last) begin
            if (sw_matches < need) begin
               sw_matches = sw_matches + 4'd1;
               if (sw_matches == need && sw_stable != raw) begin
                  sw_prev   = sw_stable;
                  sw_stable = raw;
                  changed   = 1'b1;
               end
            end
         end else begin
            sw_last    = raw;
            sw_matches = '0;
         end
         press = changed && sw_stable[0] && !sw_prev[0];
         case (m)
            MODE_TOGGLE: begin
               if (press) led_q = ~led_q;
               if (changed) show_decimal(sw_stable);
            end
            MODE_BLINK: begin
               if (changed && sw_stable[1:0] != sw_prev[1:0]) blink_left = '0;
               show_decimal(sw_stable);
            end
            MODE_COUNT: begin
               if (press) begin
                  press_total = (press_total >= 4'd9) ? 4'd0 : press_total + 4'd1;
                  show_decimal(press_total);
               end
            end
            MODE_BINARY: begin
               for (int i = 0; i < DIGIT_COUNT_DEF; i++)
                  glyphs[i] = DIGIT_GLYPH[sw_stable[i]];
            end
            default: begin
               if (changed) begin
                  shown_value = sw_stable;
                  show_decimal(shown_value);
               end
               led_q = shown_value[0];
            end
         endcase
         poll_left = 8'(at_least_one(10'(cfg_poll)) - 10'd1);
      end else begin
         poll_left = poll_left - 8'd1;
      end

      // Blink timer; it only runs in blink mode with a blinking setting.
      sel = sw_stable[1:0];
      if (m != MODE_BLINK) begin
         blink_left = '0;
      end else if (sel == BLINK_OFF) begin
         led_q      = 1'b0;
         blink_left = '0;
      end else if (sel == BLINK_ON) begin
         led_q      = 1'b1;
         blink_left = '0;
      end else if (blink_left == '0) begin
         led_q      = ~led_q;
         blink_left = at_least_one(sel == BLINK_SLOW ? cfg_slow : cfg_fast) - 10'd1;
      end else begin
         blink_left = blink_left - 10'd1;
      end

      res.segments        = seg_q;
      res.cathodes        = cath_q;
      res.led_on          = led_q;
      res.stable_switches = sw_stable;
   endtask

   task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Handshakes are sampled at the rising edge; the model follows each accepted word.
   always @(posedge clock) begin : track_words
      disp_word_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_display_tick(req_tdata[PIN_W-1:0], want);
            if (row_pinned) want = row_want;
            expected_words.push_back(want);
         end
         if (csr_valid && csr_ready) display_write(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_words.size() == 0) begin
               $display("%0t ns: result word %h with nothing expected", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               compare_field("segments", 8'(want.segments), 8'(got.segments));
               compare_field("cathodes", 8'(want.cathodes), 8'(got.cathodes));
               compare_field("led_on", 8'(want.led_on), 8'(got.led_on));
               compare_field("stable_switches", 8'(want.stable_switches),
                             8'(got.stable_switches));
            end
         end
      end
   end

   // Result side stalls at random unless idling is switched off.
   always @(negedge clock) begin
      rsp_tready <= gaps_on ? ($urandom_range(0, 99) >= 30) : 1'b1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("switch_debounce_display_controller_core test failed");
         $finish;
      end
   end

   // Offers one tick word and returns at the falling edge after it is taken.
   task automatic drive_tick(input logic [PIN_W-1:0] pins, input logic pinned,
                             input disp_word_type want);
      while (gaps_on && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - PIN_W){1'b0}}, pins};
      row_pinned <= pinned;
      row_want   <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all six registers and one spare index; unused upper data bits carry noise.
   task automatic program_registers(input logic [2:0] mode, input logic [3:0] debounce,
                                    input logic [7:0] poll, input logic [7:0] mux,
                                    input logic [9:0] slow, input logic [9:0] fast);
      csr_write(CSR_MODE, {7'($urandom), mode});
      csr_write(CSR_DEBOUNCE, {6'($urandom), debounce});
      csr_write(CSR_POLL, {2'($urandom), poll});
      csr_write(CSR_MUX, {2'($urandom), mux});
      csr_write(CSR_SLOW, slow);
      csr_write(CSR_FAST, fast);
      csr_write($urandom_range(0, 1) ? CSR_SPARE_FIRST : CSR_SPARE_LAST, 10'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Mostly patterns held long enough to be accepted, with short bursts of bounce.
   task automatic run_patterns(input int budget);
      int              sent, run, settle;
      logic            bounce;
      logic [PIN_W-1:0] pins;
      sent   = 0;
      settle = int'(at_least_one(10'(cfg_debounce))) * int'(at_least_one(10'(cfg_poll)));
      while (sent < budget) begin
         pins   = PIN_W'($urandom);
         bounce = ($urandom_range(0, 99) < 20);
         if (bounce)
            run = $urandom_range(1, 3);
         else
            run = settle + $urandom_range(0, 2 * int'(at_least_one(10'(cfg_poll))) + 2);
         if (run > budget - sent) run = budget - sent;
         repeat (run) begin
            if (bounce) pins = PIN_W'($urandom);
            drive_tick(pins, 1'b0, '0);
         end
         sent += run;
      end
   endtask

   // Waits until every expected word has been received.
   task automatic wait_idle();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [2:0] mode;
      display_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed ticks under the reset settings.
      foreach (DIRECTED[r])
         drive_tick(DIRECTED[r].pins, DIRECTED[r].pinned, DIRECTED[r].want);
      req_tvalid <= 1'b0;
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            3:       mode = MODE_TOGGLE;
            4:       mode = MODE_COUNT;
            5:       mode = MODE_BINARY;
            6, 7, 8: mode = 3'(MODE_RESERVED_FIRST + 3'(p - 6));
            default: mode = 3'($urandom_range(0, 7));
         endcase
         if (p == 0)
            program_registers(MODE_FOLLOW, 4'd0, 8'd0, 8'd0, 10'd0, 10'd0);
         else if (p == 1)
            program_registers(MODE_BLINK, 4'd15, 8'd255, 8'd255, 10'd1023, 10'd1023);
         else if (p == 2)
            program_registers(MODE_BLINK, 4'd15, 8'd1, 8'($urandom_range(0, 3)),
                              10'($urandom_range(0, 8)), 10'($urandom_range(0, 4)));
         else
            program_registers(mode, 4'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
                              8'($urandom_range(0, 3)), 10'($urandom_range(0, 12)),
                              10'($urandom_range(0, 6)));
         // Two phases run with both streams always ready.
         gaps_on = !(p == 5 || p == 6);
         run_patterns(p == 1 ? 200 : 95);
         req_tvalid <= 1'b0;
         wait_idle();
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("switch_debounce_display_controller_core test passed");
      else
         $display("switch_debounce_display_controller_core test failed");
      $finish;
   end

endmodule

[files.f]
hw/rtl/swdd_pkg.sv
hw/rtl/swdd_debounce.sv
hw/rtl/swdd_mode.sv
hw/rtl/swdd_display.sv
hw/rtl/switch_debounce_display_controller_core.sv
hw/rtl/swdd_checker.sv
test/switch_debounce_display_controller_core_tb.sv
